[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define OSUT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// When the condition holds, the consequence must hold in the next cycle.
`define OSUT_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`else
`define OSUT_ASSERT(lbl, clk, rst, prop, msg)
`define OSUT_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg)
`endif

`endif

[design/osut_pkg.sv]
// ----------------------------------------------------------------------------
// Oversampled UART package
// Default parameters and the status structs passed between the units.
// ----------------------------------------------------------------------------
`default_nettype none

package osut_pkg;

  localparam int TICKS_PER_BIT_DEF = 3;
  localparam int DATA_BITS_DEF     = 8;
  localparam int BYTE_W            = 8;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_status_t;

  typedef struct packed {
    logic line;
    logic done;
    logic busy;
  } tx_status_t;

endpackage

`default_nettype wire

[design/osut_if.sv]
// ----------------------------------------------------------------------------
// Oversampled UART channels
// Valid/ready interfaces for the tick input and the per-tick result.
// ----------------------------------------------------------------------------
`default_nettype none

interface osut_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       tx_request;
  logic [7:0] tx_byte;

  modport source (output valid, rx_line, tx_request, tx_byte, input ready);
  modport sink   (input valid, rx_line, tx_request, tx_byte, output ready);
endinterface

interface osut_result_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_done;
  logic       tx_busy;

  modport source (output valid, tx_line, rx_valid, rx_byte, tx_done, tx_busy, input ready);
  modport sink   (input valid, tx_line, rx_valid, rx_byte, tx_done, tx_busy, output ready);
endinterface

`default_nettype wire

[design/osut_rx.sv]
// ----------------------------------------------------------------------------
// UART receiver
// Start detection, bit-time divider and LSB-first shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module osut_rx #(
  parameter int TICKS_PER_BIT = osut_pkg::TICKS_PER_BIT_DEF,
  parameter int DATA_BITS     = osut_pkg::DATA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                line,
  output osut_pkg::rx_status_t status
);
  import osut_pkg::*;

  localparam int CNT_W  = $clog2(TICKS_PER_BIT + 1);
  localparam int BITS_W = $clog2(DATA_BITS + 2);

  logic                 active, active_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [BITS_W-1:0]    bits_left, bits_left_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [BYTE_W-1:0]    hold, hold_next;
  logic                 valid;
  logic [DATA_BITS+BYTE_W-1:0] shift_ext;

  assign shift_ext = {{BYTE_W{1'b0}}, shift};

  always_comb begin
    active_next    = active;
    cnt_next       = cnt;
    bits_left_next = bits_left;
    shift_next     = shift;
    hold_next      = hold;
    valid          = 1'b0;
    if (active) begin
      if (cnt <= CNT_W'(1)) begin
        cnt_next = CNT_W'(TICKS_PER_BIT);
        if (bits_left <= BITS_W'(1)) begin
          bits_left_next = '0;
          hold_next      = shift_ext[BYTE_W-1:0];
          active_next    = 1'b0;
          valid          = 1'b1;
        end else begin
          bits_left_next = bits_left - BITS_W'(1);
          shift_next     = {line, shift[DATA_BITS-1:1]};
        end
      end else begin
        cnt_next = cnt - CNT_W'(1);
      end
    end else if (!line) begin
      active_next    = 1'b1;
      cnt_next       = CNT_W'(TICKS_PER_BIT);
      bits_left_next = BITS_W'(DATA_BITS + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= '0;
      bits_left <= '0;
      shift     <= '0;
      hold      <= '0;
    end else if (en) begin
      active    <= active_next;
      cnt       <= cnt_next;
      bits_left <= bits_left_next;
      shift     <= shift_next;
      hold      <= hold_next;
    end
  end

  assign status.valid = valid;
  assign status.data  = hold_next;

endmodule

`default_nettype wire

[design/osut_tx.sv]
// ----------------------------------------------------------------------------
// UART transmitter
// Request latch, free-running bit divider and LSB-first output shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module osut_tx #(
  parameter int TICKS_PER_BIT = osut_pkg::TICKS_PER_BIT_DEF,
  parameter int DATA_BITS     = osut_pkg::DATA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                request,
  input  logic [7:0]          data,
  output osut_pkg::tx_status_t status
);
  import osut_pkg::*;

  localparam int CNT_W  = $clog2(TICKS_PER_BIT + 1);
  localparam int BITS_W = $clog2(DATA_BITS + 2);

  logic                 active, active_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [BITS_W-1:0]    bits_left, bits_left_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [BYTE_W-1:0]    hold, hold_next;
  logic                 level, level_next;
  logic                 fire, done;
  logic [DATA_BITS+BYTE_W-1:0] hold_ext;

  // Bits above the byte width go out as zeros.
  assign hold_ext = {{DATA_BITS{1'b0}}, hold_next};

  always_comb begin
    active_next    = active;
    bits_left_next = bits_left;
    shift_next     = shift;
    hold_next      = hold;
    level_next     = level;
    done           = 1'b0;

    // A request is taken before the divider so the start bit can leave at the first divider fire.
    if (request && !active) begin
      active_next    = 1'b1;
      hold_next      = data;
      bits_left_next = '0;
    end

    fire     = (cnt <= CNT_W'(1));
    cnt_next = fire ? CNT_W'(TICKS_PER_BIT) : cnt - CNT_W'(1);

    if (fire && active_next) begin
      if (bits_left_next == '0) begin
        level_next     = 1'b0;
        shift_next     = hold_ext[DATA_BITS-1:0];
        bits_left_next = BITS_W'(DATA_BITS + 1);
      end else begin
        shift_next     = shift >> 1;
        bits_left_next = bits_left_next - BITS_W'(1);
        if (bits_left_next == '0) begin
          level_next  = 1'b1;
          active_next = 1'b0;
          done        = 1'b1;
        end else begin
          level_next = shift[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= CNT_W'(TICKS_PER_BIT);
      bits_left <= '0;
      shift     <= '0;
      hold      <= '0;
      level     <= 1'b1;
    end else if (en) begin
      active    <= active_next;
      cnt       <= cnt_next;
      bits_left <= bits_left_next;
      shift     <= shift_next;
      hold      <= hold_next;
      level     <= level_next;
    end
  end

  assign status.line = level_next;
  assign status.done = done;
  assign status.busy = active_next;

endmodule

`default_nettype wire

[design/oversampled_uart_transceiver.sv]
// Latency: a tick accepted at one edge shows its result from the next cycle.
// Throughput: one tick per cycle while results are taken; the result register refills in the cycle it drains.
// A stalled result blocks new ticks only while it is not taken.
// Reset (synchronous, rst high): receiver idle, transmit line high,
// transmit divider at its full count, held bytes cleared, no result pending.
// ----------------------------------------------------------------------------
// Oversampled UART transceiver
// 8N1-style UART clocked by oversampling ticks, one result per tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module oversampled_uart_transceiver #(
  parameter int TICKS_PER_BIT = osut_pkg::TICKS_PER_BIT_DEF,
  parameter int DATA_BITS     = osut_pkg::DATA_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  osut_tick_if.sink     tick,
  osut_result_if.source result
);
  import osut_pkg::*;

  logic       accept;
  logic       out_valid;
  rx_status_t rx_st;
  tx_status_t tx_st;
  logic       tx_line, rx_valid, tx_done, tx_busy;
  logic [BYTE_W-1:0] rx_byte;

  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  osut_rx #(
    .TICKS_PER_BIT(TICKS_PER_BIT),
    .DATA_BITS    (DATA_BITS)
  ) u_rx (
    .clk   (clk),
    .rst   (rst),
    .en    (accept),
    .line  (tick.rx_line),
    .status(rx_st)
  );

  osut_tx #(
    .TICKS_PER_BIT(TICKS_PER_BIT),
    .DATA_BITS    (DATA_BITS)
  ) u_tx (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .request(tick.tx_request),
    .data   (tick.tx_byte),
    .status (tx_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_line  <= tx_st.line;
      rx_valid <= rx_st.valid;
      rx_byte  <= rx_st.data;
      tx_done  <= tx_st.done;
      tx_busy  <= tx_st.busy;
    end
  end

  assign result.valid    = out_valid;
  assign result.tx_line  = tx_line;
  assign result.rx_valid = rx_valid;
  assign result.rx_byte  = rx_byte;
  assign result.tx_done  = tx_done;
  assign result.tx_busy  = tx_busy;

  `OSUT_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, out_valid, "tick gave no result")
  `OSUT_ASSERT(a_empty_is_ready, clk, rst, !out_valid |-> tick.ready, "empty but not ready")
  `OSUT_ASSERT(a_done_line_idle, clk, rst, out_valid && tx_done |-> tx_line && !tx_busy, "bad stop")

endmodule

`default_nettype wire
